>>> sv/h264_rtp_packetizer_unit_macros.svh
// Assertion helpers shared by the packetizer RTL.
// Both sample on clk and stay quiet while rst_n is low.
`ifndef H264_RTP_PACKETIZER_UNIT_MACROS_SVH
`define H264_RTP_PACKETIZER_UNIT_MACROS_SVH

// Same-cycle implication.
`define H264RTP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: ante -> cons");

// Next-cycle implication.
`define H264RTP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: ante => cons");

`endif

>>> sv/h264rtp_pkg.sv
package h264rtp_pkg;

  localparam int LENGTH_WIDTH_DEF = 24;

  // Configuration register indexes
  localparam logic [1:0] CFG_SSRC     = 2'd0;
  localparam logic [1:0] CFG_PT       = 2'd1;
  localparam logic [1:0] CFG_TS_INC   = 2'd2;
  localparam logic [1:0] CFG_MAX_PAY  = 2'd3;

  localparam logic [31:0] SSRC_RESET     = 32'h8892_3423;
  localparam logic [6:0]  PT_RESET       = 7'd96;
  localparam logic [31:0] TS_INC_RESET   = 32'd3600;
  localparam logic [13:0] MAX_PAY_RESET  = 14'd1400;
  localparam logic [31:0] TS_RESET       = 32'd450;
  localparam logic [13:0] MIN_PAYLOAD    = 14'd2;

  // Packet byte constants
  localparam logic [7:0] INTERLEAVE_MAGIC = 8'h24;
  localparam logic [7:0] RTP_V2_BYTE      = 8'h80;
  localparam logic [7:0] NRI_MASK         = 8'hE0;
  localparam logic [7:0] FU_A_TYPE        = 8'd28;
  localparam logic [15:0] RTP_HDR_LEN     = 16'd12;
  localparam logic [15:0] FU_OVERHEAD     = 16'd14;

  // Byte slot numbering inside one run
  localparam logic [4:0] IDX_HDR_LAST = 5'd15;
  localparam logic [4:0] IDX_FU_IND   = 5'd16;
  localparam logic [4:0] IDX_FU_HDR   = 5'd17;
  localparam logic [4:0] IDX_DATA     = 5'd18;

  typedef logic [4:0] byte_idx_t;

  // Everything needed to serialize the results of one input transaction
  typedef struct packed {
    logic        hdr_en;
    logic        fu_en;
    logic [7:0]  chan2;
    logic [15:0] plen;
    logic [6:0]  pt;
    logic [15:0] seq;
    logic [31:0] ts;
    logic [31:0] ssrc;
    logic [7:0]  fu_ind;
    logic [7:0]  fu_hdr;
    logic [7:0]  data;
    logic        pkt_end;
    logic        key;
  } h264rtp_desc_t;

endpackage

>>> sv/h264rtp_emit.sv
module h264rtp_emit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load_en,
  input  h264rtp_pkg::h264rtp_desc_t load_desc,
  output logic                   skid_full,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             out_out_byte,
  output logic                   out_packet_end,
  output logic                   out_last_of_run,
  output logic                   out_key_frame_tag
);
  import h264rtp_pkg::*;

  h264rtp_desc_t act_r, act_nxt, pend_r, pend_nxt;
  logic          act_v_r, act_v_nxt, pend_v_r, pend_v_nxt;
  byte_idx_t     idx_r, idx_nxt;
  logic          out_fire, act_done, act_free;

  function automatic byte_idx_t start_idx(input h264rtp_desc_t d);
    return d.hdr_en ? '0 : IDX_DATA;
  endfunction

  assign out_fire  = act_v_r && !out_stall;
  assign act_done  = out_fire && (idx_r == IDX_DATA);
  assign act_free  = !act_v_r || act_done;
  assign skid_full = pend_v_r;

  always_comb begin
    act_nxt    = act_r;
    act_v_nxt  = act_v_r;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    idx_nxt    = idx_r;
    if (act_free) begin
      if (pend_v_r) begin
        act_nxt    = pend_r;
        act_v_nxt  = 1'b1;
        pend_v_nxt = 1'b0;
        idx_nxt    = start_idx(pend_r);
      end else if (load_en) begin
        act_nxt   = load_desc;
        act_v_nxt = 1'b1;
        idx_nxt   = start_idx(load_desc);
      end else begin
        act_v_nxt = 1'b0;
      end
    end else begin
      if (load_en) begin
        pend_nxt   = load_desc;
        pend_v_nxt = 1'b1;
      end
      if (out_fire) begin
        // skip the FU bytes for a whole-NAL packet
        idx_nxt = (idx_r == IDX_HDR_LAST && !act_r.fu_en) ? IDX_DATA : idx_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_v_r  <= 1'b0;
      pend_v_r <= 1'b0;
      idx_r    <= '0;
    end else begin
      act_v_r  <= act_v_nxt;
      pend_v_r <= pend_v_nxt;
      idx_r    <= idx_nxt;
    end
    act_r  <= act_nxt;
    pend_r <= pend_nxt;
  end

  always_comb begin
    case (idx_r)
      5'd0:       out_out_byte = INTERLEAVE_MAGIC;
      5'd1:       out_out_byte = act_r.chan2;
      5'd2:       out_out_byte = act_r.plen[15:8];
      5'd3:       out_out_byte = act_r.plen[7:0];
      5'd4:       out_out_byte = RTP_V2_BYTE;
      5'd5:       out_out_byte = {1'b0, act_r.pt};
      5'd6:       out_out_byte = act_r.seq[15:8];
      5'd7:       out_out_byte = act_r.seq[7:0];
      5'd8:       out_out_byte = act_r.ts[31:24];
      5'd9:       out_out_byte = act_r.ts[23:16];
      5'd10:      out_out_byte = act_r.ts[15:8];
      5'd11:      out_out_byte = act_r.ts[7:0];
      5'd12:      out_out_byte = act_r.ssrc[31:24];
      5'd13:      out_out_byte = act_r.ssrc[23:16];
      5'd14:      out_out_byte = act_r.ssrc[15:8];
      IDX_HDR_LAST: out_out_byte = act_r.ssrc[7:0];
      IDX_FU_IND: out_out_byte = act_r.fu_ind;
      IDX_FU_HDR: out_out_byte = act_r.fu_hdr;
      IDX_DATA:   out_out_byte = act_r.data;
      default:    out_out_byte = act_r.data;
    endcase
  end

  assign out_valid         = act_v_r;
  assign out_last_of_run   = (idx_r == IDX_DATA);
  assign out_packet_end    = (idx_r == IDX_DATA) && act_r.pkt_end;
  assign out_key_frame_tag = act_r.key;

endmodule

>>> sv/h264_rtp_packetizer_unit.sv
// Latency: the first result of an accepted transaction is valid the next cycle
// when the output slot is free; otherwise it waits behind the run in that slot.
// Throughput, out_stall low: one transaction per cycle while each yields a single
// payload byte; a transaction that opens a packet yields 17 or 19 bytes, one per
// cycle, and the input then takes at most one more until that run leaves the slot.
// Reset: synchronous, active low; registers return to defaults, sequence 0,
// timestamp 450, and both output slots empty.
`include "h264_rtp_packetizer_unit_macros.svh"

module h264_rtp_packetizer_unit #(
  parameter int LENGTH_WIDTH = h264rtp_pkg::LENGTH_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // configuration
  input  logic                    cfg_wr_en,
  input  logic [1:0]              cfg_index,
  input  logic [31:0]             cfg_wr_data,
  // NAL byte stream
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              in_data_byte,
  input  logic [LENGTH_WIDTH-1:0] in_frame_length,
  input  logic [6:0]              in_channel_number,
  input  logic                    in_key_frame_flag,
  // packet byte stream
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [7:0]              out_out_byte,
  output logic                    out_packet_end,
  output logic                    out_last_of_run,
  output logic                    out_key_frame_tag
);
  import h264rtp_pkg::*;

  // compare width wide enough for both NAL lengths and the payload limit
  localparam int CW = (LENGTH_WIDTH > 14) ? LENGTH_WIDTH : 14;

  // configuration registers
  logic [31:0] ssrc_r, ts_inc_r;
  logic [6:0]  pt_r;
  logic [13:0] max_pay_r;

  // packetizer state
  logic [15:0]             seq_r, seq_nxt;
  logic [31:0]             ts_r, ts_nxt;
  logic [LENGTH_WIDTH-1:0] pos_r, pos_nxt;
  logic [13:0]             fill_r, fill_nxt;
  logic [7:0]              nal_r, nal_nxt;
  logic                    frag_mode_r, frag_mode_nxt;
  logic [LENGTH_WIDTH-1:0] total_r, total_nxt;
  logic [6:0]              chan_r, chan_nxt;
  logic                    key_r, key_nxt;
  logic [13:0]             limit_r, limit_nxt;
  logic [13:0]             frag_size_r, frag_size_nxt;

  // per-transaction working values
  logic                    in_fire, first, frame_done, first_frag, new_frag, frag_end;
  logic [LENGTH_WIDTH-1:0] cur_total, remaining;
  logic [LENGTH_WIDTH:0]   pos_p1;
  logic [13:0]             cur_limit, fs, fs_eff, fill_p1;
  logic                    cur_fm, cur_key;
  logic [6:0]              cur_chan;
  logic [7:0]              cur_nal;
  logic [CW-1:0]           rem_c, lim_c, fs_c;
  logic                    load_en, skid_full;
  h264rtp_desc_t           load_desc;

  assign in_stall = skid_full;
  assign in_fire  = in_valid && !in_stall;
  assign first    = (pos_r == '0);

  // latch the NAL-wide values on its first byte
  always_comb begin
    cur_total = first ? ((in_frame_length == '0) ? LENGTH_WIDTH'(1) : in_frame_length)
                      : total_r;
    cur_limit = first ? ((max_pay_r < MIN_PAYLOAD) ? MIN_PAYLOAD : max_pay_r) : limit_r;
    cur_chan  = first ? in_channel_number : chan_r;
    cur_key   = first ? in_key_frame_flag : key_r;
    cur_nal   = first ? in_data_byte : nal_r;
    cur_fm    = first ? (CW'(cur_total) > CW'(cur_limit)) : frag_mode_r;
  end

  // fragment sizing; a lone fragment is split so S and E never coincide
  always_comb begin
    pos_p1     = {1'b0, pos_r} + (LENGTH_WIDTH+1)'(1);
    frame_done = pos_p1 >= {1'b0, cur_total};
    remaining  = cur_total - pos_r;
    rem_c      = CW'(remaining);
    lim_c      = CW'(cur_limit);
    first_frag = (pos_r == LENGTH_WIDTH'(1));
    fs_c       = (rem_c < lim_c) ? rem_c : lim_c;
    if (first_frag && rem_c <= lim_c) begin
      fs_c = rem_c - CW'(1);
    end
    fs       = fs_c[13:0];
    new_frag = (fill_r == '0);
    fs_eff   = new_frag ? fs : frag_size_r;
    fill_p1  = fill_r + 14'd1;
    frag_end = (fill_p1 >= fs_eff) || frame_done;
  end

  always_comb begin
    load_desc         = '0;
    load_desc.chan2   = {cur_chan, 1'b0};
    load_desc.pt      = pt_r;
    load_desc.seq     = seq_r;
    load_desc.ts      = ts_r;
    load_desc.ssrc    = ssrc_r;
    load_desc.fu_ind  = (cur_nal & NRI_MASK) | FU_A_TYPE;
    load_desc.fu_hdr  = {first_frag, (CW'(fs) == rem_c), 1'b0, cur_nal[4:0]};
    load_desc.data    = in_data_byte;
    load_desc.key     = cur_key;

    seq_nxt       = seq_r;
    ts_nxt        = ts_r;
    pos_nxt       = pos_r;
    fill_nxt      = fill_r;
    nal_nxt       = nal_r;
    frag_mode_nxt = frag_mode_r;
    total_nxt     = total_r;
    chan_nxt      = chan_r;
    key_nxt       = key_r;
    limit_nxt     = limit_r;
    frag_size_nxt = frag_size_r;
    load_en       = 1'b0;

    if (in_fire) begin
      total_nxt     = cur_total;
      limit_nxt     = cur_limit;
      chan_nxt      = cur_chan;
      key_nxt       = cur_key;
      nal_nxt       = cur_nal;
      frag_mode_nxt = cur_fm;
      if (!cur_fm) begin
        // whole NAL in one packet
        load_en           = 1'b1;
        load_desc.hdr_en  = first;
        load_desc.plen    = 16'(cur_total) + RTP_HDR_LEN;
        load_desc.pkt_end = frame_done;
        if (frame_done) begin
          seq_nxt = seq_r + 16'd1;
        end
      end else if (!first) begin
        // FU-A fragment byte; first NAL byte (the header) yields nothing
        load_en           = 1'b1;
        load_desc.hdr_en  = new_frag;
        load_desc.fu_en   = new_frag;
        load_desc.plen    = 16'(fs) + FU_OVERHEAD;
        load_desc.pkt_end = frag_end;
        if (new_frag) begin
          frag_size_nxt = fs;
        end
        if (frag_end) begin
          fill_nxt = '0;
          seq_nxt  = seq_r + 16'd1;
        end else begin
          fill_nxt = fill_p1;
        end
      end else begin
        fill_nxt = '0;
      end
      if (frame_done) begin
        pos_nxt       = '0;
        frag_mode_nxt = 1'b0;
        fill_nxt      = '0;
        ts_nxt        = ts_r + ts_inc_r;
      end else begin
        pos_nxt = pos_r + LENGTH_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ssrc_r      <= SSRC_RESET;
      pt_r        <= PT_RESET;
      ts_inc_r    <= TS_INC_RESET;
      max_pay_r   <= MAX_PAY_RESET;
      seq_r       <= '0;
      ts_r        <= TS_RESET;
      pos_r       <= '0;
      fill_r      <= '0;
      nal_r       <= '0;
      frag_mode_r <= 1'b0;
      total_r     <= '0;
      chan_r      <= '0;
      key_r       <= 1'b0;
      limit_r     <= '0;
      frag_size_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_SSRC:    ssrc_r    <= cfg_wr_data;
          CFG_PT:      pt_r      <= cfg_wr_data[6:0];
          CFG_TS_INC:  ts_inc_r  <= cfg_wr_data;
          CFG_MAX_PAY: max_pay_r <= cfg_wr_data[13:0];
        endcase
      end
      seq_r       <= seq_nxt;
      ts_r        <= ts_nxt;
      pos_r       <= pos_nxt;
      fill_r      <= fill_nxt;
      nal_r       <= nal_nxt;
      frag_mode_r <= frag_mode_nxt;
      total_r     <= total_nxt;
      chan_r      <= chan_nxt;
      key_r       <= key_nxt;
      limit_r     <= limit_nxt;
      frag_size_r <= frag_size_nxt;
    end
  end

  // serialize each transaction's bytes through an output slot plus a skid slot
  h264rtp_emit u_emit (
    .clk               (clk),
    .rst_n             (rst_n),
    .load_en           (load_en),
    .load_desc         (load_desc),
    .skid_full         (skid_full),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_out_byte      (out_out_byte),
    .out_packet_end    (out_packet_end),
    .out_last_of_run   (out_last_of_run),
    .out_key_frame_tag (out_key_frame_tag)
  );

  // a packet only closes on the data byte that ends a run
  `H264RTP_ASSERT_IMPL(a_end_is_last, out_valid && out_packet_end, out_last_of_run)
  // a full skid slot means the output slot is busy
  `H264RTP_ASSERT_IMPL(a_skid_behind_out, in_stall, out_valid)
  // inside a fragment the fill stays below the fragment size
  `H264RTP_ASSERT_IMPL(a_fill_bound, frag_mode_r && fill_r != '0, fill_r < frag_size_r)
  // the final NAL byte rewinds the position
  `H264RTP_ASSERT_NEXT(a_nal_rewind, in_fire && frame_done, pos_r == '0)

endmodule

>>> tb/tb_h264_rtp_packetizer_unit.sv
`timescale 1ns / 1ps

module tb_h264_rtp_packetizer_unit;
  import h264rtp_pkg::*;

  localparam int SETTLE_CYCLES = 6;    // quiet time before a register write
  localparam int DRAIN_CYCLES  = 24;   // tail after the last expected byte
  localparam int HOLD_CYCLES   = 150;  // long receiver hold-off
  localparam int QUIET_LIMIT   = 5000; // cycles with no transaction at all
  localparam int RAND_PHASES   = 4;
  localparam int PHASE_BYTES   = 10;   // minimum NAL bytes fed per random phase
  localparam int TAIL_BYTES    = 15;   // bytes fed into the open-ended last NAL

  // One byte of the outgoing packet stream as the predictor sees it
  typedef struct packed {
    logic [7:0] octet;
    logic       pend;
    logic       last;
    logic       key;
  } pkt_byte_t;

  // One row of the directed plan: either a NAL byte or a register write.
  // exp_n < 0 means the row is checked against the predictor only.
  typedef struct packed {
    logic        is_cfg;
    logic [1:0]  idx;
    logic [31:0] val;
    logic [7:0]  d;
    logic [23:0] len;
    logic [6:0]  ch;
    logic        k;
    int          exp_n;
    logic [7:0]  exp_tail;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic [23:0] in_frame_length;
  logic [6:0]  in_channel_number;
  logic        in_key_frame_flag;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_out_byte;
  logic        out_packet_end;
  logic        out_last_of_run;
  logic        out_key_frame_tag;

  h264_rtp_packetizer_unit uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_frame_length   (in_frame_length),
    .in_channel_number (in_channel_number),
    .in_key_frame_flag (in_key_frame_flag),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_out_byte      (out_out_byte),
    .out_packet_end    (out_packet_end),
    .out_last_of_run   (out_last_of_run),
    .out_key_frame_tag (out_key_frame_tag)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Packetizer predictor: register copies and per-NAL state
  // ---------------------------------------------------------------------
  logic [31:0] reg_ssrc;
  logic [6:0]  reg_pt;
  logic [31:0] reg_ts_step;
  logic [13:0] reg_max_pay;

  logic [15:0] seq_no;
  logic [31:0] rtp_ts;
  int unsigned nal_pos;
  int unsigned frag_fill;
  logic [7:0]  nal_hdr;
  logic        fu_mode;
  int unsigned nal_len;
  logic [6:0]  nal_chan;
  logic        nal_key;
  int unsigned pay_limit;
  int unsigned frag_len;

  pkt_byte_t   step_out[$];      // bytes caused by the current transaction
  pkt_byte_t   pkt_bytes_due[$]; // packet bytes still owed by the block
  plan_row_t   directed_plan[$];
  pkt_byte_t   oldest;

  int          mismatch_count = 0;
  int          quiet_cycles = 0;
  bit          calm = 1'b0;      // no idling on either side while set
  bit          hold_req = 1'b0;  // ask the receiver for a long hold-off

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
  endtask

  function automatic void put_byte(input logic [7:0] b, input logic e);
    pkt_byte_t pb;
    pb.octet = b;
    pb.pend  = e;
    pb.last  = 1'b0;
    pb.key   = nal_key;
    step_out.push_back(pb);
  endfunction

  // Interleave prefix plus the 12-byte RTP header, all big-endian
  function automatic void emit_rtp_header(input int unsigned payload);
    logic [15:0] plen;
    plen = 16'(payload + 32'(RTP_HDR_LEN));
    put_byte(INTERLEAVE_MAGIC, 1'b0);
    put_byte({nal_chan, 1'b0}, 1'b0);
    put_byte(plen[15:8], 1'b0);
    put_byte(plen[7:0], 1'b0);
    put_byte(RTP_V2_BYTE, 1'b0);
    put_byte({1'b0, reg_pt}, 1'b0);
    put_byte(seq_no[15:8], 1'b0);
    put_byte(seq_no[7:0], 1'b0);
    put_byte(rtp_ts[31:24], 1'b0);
    put_byte(rtp_ts[23:16], 1'b0);
    put_byte(rtp_ts[15:8], 1'b0);
    put_byte(rtp_ts[7:0], 1'b0);
    put_byte(reg_ssrc[31:24], 1'b0);
    put_byte(reg_ssrc[23:16], 1'b0);
    put_byte(reg_ssrc[15:8], 1'b0);
    put_byte(reg_ssrc[7:0], 1'b0);
  endfunction

  function automatic void reset_packetizer();
    reg_ssrc    = SSRC_RESET;
    reg_pt      = PT_RESET;
    reg_ts_step = TS_INC_RESET;
    reg_max_pay = MAX_PAY_RESET;
    seq_no      = '0;
    rtp_ts      = TS_RESET;
    nal_pos     = 0;
    frag_fill   = 0;
    nal_hdr     = '0;
    fu_mode     = 1'b0;
    nal_len     = 0;
    nal_chan    = '0;
    nal_key     = 1'b0;
    pay_limit   = 0;
    frag_len    = 0;
  endfunction

  // Work out every packet byte that one accepted NAL byte causes and queue it
  task automatic packetize_byte(input logic [7:0] b, input logic [23:0] flen,
                                input logic [6:0] ch, input logic k,
                                output int cnt, output logic [7:0] tail);
    int unsigned remaining;
    bit          opening;
    bit          nal_done;
    logic [7:0]  fu;
    pkt_byte_t   pb;
    step_out.delete();
    // Latch the NAL's shape on its header byte
    if (nal_pos == 0) begin
      nal_len   = (flen == 24'd0) ? 1 : 32'(flen);
      nal_chan  = ch;
      nal_key   = k;
      pay_limit = (32'(reg_max_pay) < 32'(MIN_PAYLOAD)) ? 32'(MIN_PAYLOAD) : 32'(reg_max_pay);
      nal_hdr   = b;
      fu_mode   = (nal_len > pay_limit);
      frag_fill = 0;
      if (!fu_mode)
        emit_rtp_header(nal_len);
    end
    nal_done = (nal_pos + 1 >= nal_len);
    if (!fu_mode) begin
      put_byte(b, nal_done);
      if (nal_done)
        seq_no = seq_no + 16'd1;
    end else if (nal_pos != 0) begin
      if (frag_fill == 0) begin
        remaining = nal_len - nal_pos;
        opening   = (nal_pos == 1);
        frag_len  = (remaining < pay_limit) ? remaining : pay_limit;
        // keep S and E apart: a first fragment that would end the NAL gives up a byte
        if (opening && remaining <= pay_limit)
          frag_len = remaining - 1;
        fu = {3'b000, nal_hdr[4:0]};
        if (opening)
          fu[7] = 1'b1;
        if (frag_len == remaining)
          fu[6] = 1'b1;
        emit_rtp_header(frag_len + 2);
        put_byte((nal_hdr & NRI_MASK) | FU_A_TYPE, 1'b0);
        put_byte(fu, 1'b0);
      end
      frag_fill++;
      if (frag_fill >= frag_len || nal_done) begin
        put_byte(b, 1'b1);
        frag_fill = 0;
        seq_no = seq_no + 16'd1;
      end else begin
        put_byte(b, 1'b0);
      end
    end
    if (nal_done) begin
      nal_pos   = 0;
      fu_mode   = 1'b0;
      frag_fill = 0;
      rtp_ts    = rtp_ts + reg_ts_step;
    end else begin
      nal_pos++;
    end
    cnt  = step_out.size();
    tail = '0;
    for (int i = 0; i < cnt; i++) begin
      pb = step_out[i];
      pb.last = (i == cnt - 1);
      tail = pb.octet;
      pkt_bytes_due.push_back(pb);
    end
  endtask

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Offer one NAL byte, hold it until the transaction completes, then predict
  task automatic send_byte(input logic [7:0] d, input logic [23:0] flen,
                           input logic [6:0] ch, input logic k,
                           output int cnt, output logic [7:0] tail);
    if (!calm && $urandom_range(0, 99) < 26) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_data_byte      <= d;
    in_frame_length   <= flen;
    in_channel_number <= ch;
    in_key_frame_flag <= k;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    packetize_byte(d, flen, ch, k, cnt, tail);
  endtask

  // Drop valid and wait until every owed byte is out and the block is quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pkt_bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= val;
    @(posedge clk);
    case (idx)
      CFG_SSRC:    reg_ssrc    = val;
      CFG_PT:      reg_pt      = val[6:0];
      CFG_TS_INC:  reg_ts_step = val;
      CFG_MAX_PAY: reg_max_pay = val[13:0];
      default: ;
    endcase
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Feed nbytes of a NAL whose header byte announces len; fields on later
  // bytes are noise the block must ignore
  task automatic send_nal(input logic [23:0] len, input int nbytes);
    int         cnt;
    logic [7:0] tail;
    for (int i = 0; i < nbytes; i++) begin
      if (i == 0)
        send_byte(8'($urandom), len, 7'($urandom), 1'($urandom), cnt, tail);
      else
        send_byte(8'($urandom), 24'($urandom), 7'($urandom), 1'($urandom), cnt, tail);
    end
  endtask

  function automatic void plan_byte(input logic [7:0] d, input logic [23:0] len,
                                    input logic [6:0] ch, input logic k,
                                    input int n, input logic [7:0] tail);
    plan_row_t r;
    r = '0;
    r.d = d;
    r.len = len;
    r.ch = ch;
    r.k = k;
    r.exp_n = n;
    r.exp_tail = tail;
    directed_plan.push_back(r);
  endfunction

  function automatic void plan_reg(input logic [1:0] idx, input logic [31:0] val);
    plan_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.val = val;
    directed_plan.push_back(r);
  endfunction

  // ---------------------------------------------------------------------
  // Receiver: random stalls, one long hold-off on request, calm stretches
  // ---------------------------------------------------------------------
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else begin
        out_stall <= (!calm && $urandom_range(0, 99) < 26);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Checker: each accepted output transaction against the oldest owed byte
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pkt_bytes_due.size() == 0) begin
        report("unexpected packet byte", 32'(out_out_byte), 32'd0);
      end else begin
        oldest = pkt_bytes_due.pop_front();
        if (out_out_byte !== oldest.octet)
          report("out_byte", 32'(out_out_byte), 32'(oldest.octet));
        if (out_packet_end !== oldest.pend)
          report("packet_end", 32'(out_packet_end), 32'(oldest.pend));
        if (out_last_of_run !== oldest.last)
          report("last_of_run", 32'(out_last_of_run), 32'(oldest.last));
        if (out_key_frame_tag !== oldest.key)
          report("key_frame_tag", 32'(out_key_frame_tag), 32'(oldest.key));
      end
    end
  end

  // Watchdog: any transaction or register write restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    int         cnt;
    int         started;
    int         r;
    logic [7:0] tail;
    logic [23:0] len;
    plan_row_t  row;

    rst_n             = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_index         = CFG_SSRC;
    cfg_wr_data       = '0;
    in_valid          = 1'b0;
    in_data_byte      = '0;
    in_frame_length   = '0;
    in_channel_number = '0;
    in_key_frame_flag = 1'b0;
    reset_packetizer();

    // Directed plan. Defaults after reset: limit 1400, SSRC 0x88923423.
    // A whole packet is 16 header bytes plus the payload; a fragment adds
    // the FU indicator and FU header.
    plan_byte(8'hFF, 24'd1, 7'd127, 1'b1, 17, 8'hFF);        // all-ones byte, top channel
    plan_byte(8'h00, 24'd0, 7'd0, 1'b0, 17, 8'h00);          // zero length counts as one
    plan_byte(8'h65, 24'd3, 7'd5, 1'b1, 17, 8'h65);          // three-byte NAL opens a packet
    plan_byte(8'h00, 24'hFF_FFFF, 7'd0, 1'b0, 1, 8'h00);     // length ignored mid-NAL
    plan_byte(8'hAA, 24'd3, 7'd127, 1'b0, 1, 8'hAA);         // closes the packet
    plan_reg(CFG_MAX_PAY, 32'd1);                            // below two acts as two
    plan_byte(8'hFF, 24'd3, 7'd3, 1'b1, 0, 8'h00);           // fragmented header byte: held
    plan_byte(8'h11, 24'd0, 7'd0, 1'b0, 19, 8'h11);          // start fragment cut to one byte
    plan_byte(8'h22, 24'd0, 7'd0, 1'b0, 19, 8'h22);          // end fragment
    plan_byte(8'h41, 24'd4, 7'd1, 1'b0, 0, 8'h00);
    plan_byte(8'h01, 24'd9, 7'd9, 1'b1, 19, 8'h01);          // start fragment, two bytes
    plan_byte(8'h02, 24'd9, 7'd9, 1'b1, 1, 8'h02);
    plan_byte(8'h03, 24'd9, 7'd9, 1'b1, 19, 8'h03);          // end fragment
    plan_byte(8'h67, 24'd2, 7'd64, 1'b0, 17, 8'h67);         // length equal to limit: whole
    plan_byte(8'h68, 24'd2, 7'd64, 1'b0, 1, 8'h68);
    plan_reg(CFG_SSRC, 32'h0000_0000);
    plan_reg(CFG_PT, 32'hFFFF_FFFF);                         // masked to 127
    plan_reg(CFG_TS_INC, 32'hFFFF_FFFF);                     // timestamp walks backward
    plan_reg(CFG_MAX_PAY, 32'd8192);
    plan_byte(8'h5A, 24'd1, 7'd42, 1'b1, 17, 8'h5A);
    plan_byte(8'hA5, 24'd1, 7'd43, 1'b0, 17, 8'hA5);
    plan_reg(CFG_SSRC, 32'hFFFF_FFFF);
    plan_reg(CFG_PT, 32'd0);
    plan_reg(CFG_TS_INC, 32'd0);
    plan_reg(CFG_MAX_PAY, 32'h0000_3FFF);
    plan_byte(8'h06, 24'd1, 7'd0, 1'b1, 17, 8'h06);
    plan_byte(8'hC3, 24'd1, 7'd127, 1'b0, 17, 8'hC3);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the plan; register rows wait for the block to go quiet first
    foreach (directed_plan[i]) begin
      row = directed_plan[i];
      if (row.is_cfg) begin
        settle();
        write_reg(row.idx, row.val);
      end else begin
        send_byte(row.d, row.len, row.ch, row.k, cnt, tail);
        if (row.exp_n >= 0) begin
          if (cnt != row.exp_n)
            report("directed byte count", 32'(cnt), 32'(row.exp_n));
          else if (cnt > 0 && tail !== row.exp_tail)
            report("directed final byte", 32'(tail), 32'(row.exp_tail));
        end
      end
    end

    // Random phases: fresh registers each time, mostly small limits so
    // that most NALs split into fragments
    for (int p = 0; p < RAND_PHASES; p++) begin
      settle();
      write_reg(CFG_SSRC, $urandom);
      write_reg(CFG_PT, $urandom);
      write_reg(CFG_TS_INC, $urandom);
      r = $urandom_range(0, 9);
      if (r == 0)
        write_reg(CFG_MAX_PAY, 32'd8192);
      else if (r == 1)
        write_reg(CFG_MAX_PAY, $urandom_range(0, 1));
      else if (r == 2)
        write_reg(CFG_MAX_PAY, $urandom_range(13, 40));
      else
        write_reg(CFG_MAX_PAY, $urandom_range(2, 12));
      calm = (p == 2);
      // in the last phase, starve the output so the block backs up its input
      if (p == 3)
        hold_req = 1'b1;
      started = 0;
      while (started < PHASE_BYTES) begin
        r = $urandom_range(0, 19);
        if (r == 0)
          len = 24'd0;
        else if (r < 16)
          len = 24'($urandom_range(1, 24));
        else
          len = 24'($urandom_range(25, 60));
        send_nal(len, (len == 24'd0) ? 1 : int'(len));
        started += (len == 24'd0) ? 1 : int'(len);
      end
    end
    calm = 1'b0;

    // Largest announced length: feed its start only, no register write follows
    send_nal(24'hFF_FFFF, TAIL_BYTES);

    in_valid <= 1'b0;
    while (pkt_bytes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
